[design/spq_pkg.sv]
// spq_pkg: types, codes and sizes shared by the sorted priority queue files
// depends on nothing; imported by spq_if.sv, spq_cell.sv, spq_out_buf.sv and the top level
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int OCC_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// one slot of the sorted row
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] rank;
	} entry_t;

	// command broadcast to every cell in a cycle
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] rank;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] removed_value;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
		logic                     queue_empty;
	} result_t;

endpackage

[design/spq_if.sv]
// spq_in_if / spq_out_if: valid/ready channels of the sorted priority queue
// depends on spq_pkg
interface spq_in_if
	import spq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	op_t                      operation;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] item_rank;

	modport source (output valid, operation, item_value, item_rank, input ready);
	modport sink (input valid, operation, item_value, item_rank, output ready);
endinterface

interface spq_out_if
	import spq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] removed_value;
	status_t                  status;
	logic [OCC_W-1:0]         occupancy;
	logic                     queue_empty;

	modport source (output valid, removed_value, status, occupancy, queue_empty, input ready);
	modport sink (input valid, removed_value, status, occupancy, queue_empty, output ready);
endinterface

[design/spq_cell.sv]
// spq_cell: one slot of the sorted row; shifts right on insert, left on remove
// depends on spq_pkg
module spq_cell
	import spq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  entry_t left,
	input  logic   left_place,
	input  entry_t right,
	output entry_t slot,
	output logic   place
);

	entry_t slot_q;
	entry_t nxt;

	// new item belongs at or before this slot: slot empty or its rank strictly larger
	assign place = !slot_q.valid || (slot_q.rank > cmd.rank);

	always_comb begin
		nxt = slot_q;
		if (cmd.rem) begin
			nxt = right;
		end else if (cmd.ins) begin
			if (left_place) begin
				nxt = left;
			end else if (place) begin
				nxt.valid = 1'b1;
				nxt.value = cmd.value;
				nxt.rank  = cmd.rank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= nxt;
		end
	end

	assign slot = slot_q;

endmodule

[design/spq_out_buf.sv]
// spq_out_buf: two-deep result buffer between the cell row and the output channel
// depends on spq_pkg and spq_out_if
module spq_out_buf
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  result_t   din,
	output logic      can_push,
	spq_out_if.source results
);

	result_t d0_q, d1_q;
	logic    v0_q, v1_q;
	logic    pop;

	assign can_push = !v1_q;
	assign pop      = v0_q && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (pop) begin
				if (v1_q) begin
					v1_q <= push;
				end else begin
					v0_q <= push;
				end
			end else if (push) begin
				if (!v0_q) begin
					v0_q <= 1'b1;
				end else begin
					v1_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (v1_q) begin
				d0_q <= d1_q;
				if (push) begin
					d1_q <= din;
				end
			end else if (push) begin
				d0_q <= din;
			end
		end else if (push) begin
			if (!v0_q) begin
				d0_q <= din;
			end else begin
				d1_q <= din;
			end
		end
	end

	assign results.valid         = v0_q;
	assign results.removed_value = d0_q.removed_value;
	assign results.status        = d0_q.status;
	assign results.occupancy     = d0_q.occupancy;
	assign results.queue_empty   = d0_q.queue_empty;

endmodule

[design/sorted_priority_queue_top.sv]
// sorted_priority_queue_top: stable min-priority queue built as a row of sorting cells
// depends on spq_pkg, spq_if, spq_cell, spq_out_buf
//
// Takes one insert or remove beat per clock while input ready is high and returns one result
// beat for each. Entries sit in a row of CAPACITY cells kept sorted by signed rank, lowest at
// the head; equal ranks keep arrival order. Every cell compares its rank with the incoming one
// and all cells shift together at the edge that takes the beat; that same edge writes the result
// into the output buffer. The two-deep output buffer lets items keep flowing while a result
// waits; input ready drops only when both buffer slots hold results. No clearing pass is needed
// after reset. A remove on an empty queue reports the empty status with value 0, and an insert
// into a full queue is rejected with the full status.
module sorted_priority_queue_top
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    items,
	spq_out_if.source results
);

	entry_t               slots [CAPACITY];
	logic [CAPACITY-1:0]  places;
	logic [CAPACITY-1:0]  valids;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic                 accept;
	logic                 can_push;
	logic                 is_empty;
	logic                 is_full;
	cmd_t                 cmd;
	result_t              res;

	localparam entry_t EMPTY_ENTRY = '0;

	assign is_empty = !slots[0].valid;
	assign is_full  = slots[CAPACITY-1].valid;

	assign items.ready = can_push;
	assign accept      = items.valid && can_push;

	assign cmd.ins   = accept && (items.operation == OP_INSERT) && !is_full;
	assign cmd.rem   = accept && (items.operation == OP_REMOVE) && !is_empty;
	assign cmd.value = items.item_value;
	assign cmd.rank  = items.item_rank;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			entry_t left_e, right_e;
			logic   left_p;
			if (i == 0) begin : g_head
				assign left_e = EMPTY_ENTRY;
				assign left_p = 1'b0;
			end else begin : g_mid
				assign left_e = slots[i-1];
				assign left_p = places[i-1];
			end
			if (i == CAPACITY - 1) begin : g_tail
				assign right_e = EMPTY_ENTRY;
			end else begin : g_body
				assign right_e = slots[i+1];
			end
			spq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.left       (left_e),
				.left_place (left_p),
				.right      (right_e),
				.slot       (slots[i]),
				.place      (places[i])
			);
			assign valids[i] = slots[i].valid;
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_comb begin
		res.removed_value = '0;
		res.occupancy     = OCC_W'(count_nxt);
		res.queue_empty   = (count_nxt == '0);
		if (items.operation == OP_REMOVE) begin
			if (is_empty) begin
				res.status = ST_EMPTY;
			end else begin
				res.status        = ST_REMOVED;
				res.removed_value = slots[0].value;
			end
		end else begin
			res.status = is_full ? ST_FULL : ST_INSERTED;
		end
	end

	spq_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.din      (res),
		.can_push (can_push),
		.results  (results)
	);

	// count tracks the number of occupied cells
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(valids))
		else $error("entry count differs from occupied cells");

	// occupied cells form a prefix of the row
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valids >> 1) & ~valids) == '0)
		else $error("hole in the cell row");

	// head rank never exceeds the second cell's rank
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		valids[1] |-> (slots[0].rank <= slots[1].rank))
		else $error("head of row out of order");

	// a successful remove shrinks the queue by one
	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not decrement count");

	// a rejected insert leaves the count alone
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && items.operation == OP_INSERT && is_full) |=> $stable(count_q))
		else $error("rejected insert changed count");

endmodule

[tb/sorted_priority_queue_top_test.sv]
// sorted_priority_queue_top_test: self-checking bench for the stable min-priority queue
// depends on spq_pkg, spq_if and sorted_priority_queue_top; a short table of hand-picked inserts
// and removes, then random bursts; a shadow sorted queue predicts each result the table leaves open
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
	import spq_pkg::*;

	localparam int HOLD_CYCLES  = 120;
	localparam int RANDOM_ITEMS = 276;

	typedef struct {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] rank;
		bit                       fixed;
		result_t                  outcome;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_in_if  items_ch ();
	spq_out_if results_ch ();

	sorted_priority_queue_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	always #5 clk = ~clk;

	// shadow copy of the sorted storage
	logic signed [DATA_W-1:0] shadow_value [CAPACITY];
	logic signed [DATA_W-1:0] shadow_rank  [CAPACITY];
	int                       shadow_count;

	result_t due_results [$];
	row_t    table_rows [$];

	bit      beat_fixed;
	result_t beat_outcome;

	int send_idle_pct;
	int recv_idle_pct;
	int stall_requests;
	int errors;
	int n_items;
	int n_inserted, n_removed, n_empty, n_full;

	function automatic result_t shadow_queue_op(op_t op, logic signed [DATA_W-1:0] value,
			logic signed [DATA_W-1:0] rank);
		result_t r;
		int      pos;
		r = '0;
		if (op == OP_REMOVE) begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed_value = shadow_value[0];
				for (int i = 1; i < shadow_count; i++) begin
					shadow_value[i-1] = shadow_value[i];
					shadow_rank[i-1]  = shadow_rank[i];
				end
				shadow_count--;
				r.status = ST_REMOVED;
			end
		end else if (shadow_count >= CAPACITY) begin
			r.status = ST_FULL;
		end else begin
			// equal ranks go behind the ones already held
			pos = 0;
			while (pos < shadow_count && shadow_rank[pos] <= rank)
				pos++;
			for (int i = shadow_count; i > pos; i--) begin
				shadow_value[i] = shadow_value[i-1];
				shadow_rank[i]  = shadow_rank[i-1];
			end
			shadow_value[pos] = value;
			shadow_rank[pos]  = rank;
			shadow_count++;
			r.status = ST_INSERTED;
		end
		r.occupancy   = shadow_count[OCC_W-1:0];
		r.queue_empty = (shadow_count == 0);
		return r;
	endfunction

	// output side first, then the input beat of the same edge
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready) begin
				got.removed_value = results_ch.removed_value;
				got.status        = results_ch.status;
				got.occupancy     = results_ch.occupancy;
				got.queue_empty   = results_ch.queue_empty;
				case (got.status)
					ST_INSERTED: n_inserted++;
					ST_REMOVED:  n_removed++;
					ST_EMPTY:    n_empty++;
					default:     n_full++;
				endcase
				if (due_results.size() == 0) begin
					errors++;
					$error("result beat with nothing expected: status %0d value %0d",
						got.status, got.removed_value);
				end else begin
					want = due_results.pop_front();
					if (got.removed_value !== want.removed_value) begin
						errors++;
						$error("removed_value: expected %0d, got %0d",
							want.removed_value, got.removed_value);
					end
					if (got.status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, got.status);
					end
					if (got.occupancy !== want.occupancy) begin
						errors++;
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, got.occupancy);
					end
					if (got.queue_empty !== want.queue_empty) begin
						errors++;
						$error("queue_empty: expected %0d, got %0d",
							want.queue_empty, got.queue_empty);
					end
				end
			end
			if (items_ch.valid && items_ch.ready) begin
				want = shadow_queue_op(items_ch.operation, items_ch.item_value,
					items_ch.item_rank);
				due_results.push_back(beat_fixed ? beat_outcome : want);
			end
		end
	end

	// receiver: random ready, or a long counted hold-off on request
	initial begin
		int served;
		int hold_left;
		served    = 0;
		hold_left = 0;
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && stall_requests != served) begin
				served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(op_t op, logic signed [DATA_W-1:0] value,
			logic signed [DATA_W-1:0] rank, bit fixed, result_t outcome);
		while ($urandom_range(99) < send_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(negedge clk);
		end
		items_ch.valid      <= 1'b1;
		items_ch.operation  <= op;
		items_ch.item_value <= value;
		items_ch.item_rank  <= rank;
		beat_fixed          <= fixed;
		beat_outcome        <= outcome;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		n_items++;
		@(negedge clk);
	endtask

	function automatic void add_row(op_t op, logic signed [DATA_W-1:0] value,
			logic signed [DATA_W-1:0] rank, bit fixed, status_t st, int occ);
		row_t row;
		row.op                    = op;
		row.value                 = value;
		row.rank                  = rank;
		row.fixed                 = fixed;
		row.outcome.removed_value = '0;
		row.outcome.status        = st;
		row.outcome.occupancy     = occ[OCC_W-1:0];
		row.outcome.queue_empty   = (occ == 0);
		table_rows.push_back(row);
	endfunction

	function automatic logic signed [DATA_W-1:0] random_rank();
		case ($urandom_range(3))
			0: return $signed($urandom_range(6)) - 3;
			1: case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 0;
				default: return -1;
			endcase
			default: return $urandom;
		endcase
	endfunction

	// bursts that lean toward filling, draining or neither
	task automatic run_random(int count);
		int      left;
		int      burst;
		int      ins_pct;
		op_t     op;
		result_t none;
		none = '0;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(4, 24);
			case ($urandom_range(2))
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			for (int k = 0; k < burst && left > 0; k++) begin
				op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
				send_beat(op, $urandom, random_rank(), 1'b0, none);
				left--;
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		items_ch.valid      = 1'b0;
		items_ch.operation  = OP_INSERT;
		items_ch.item_value = '0;
		items_ch.item_rank  = '0;
		beat_fixed          = 1'b0;
		beat_outcome        = '0;
		shadow_count        = 0;
		stall_requests      = 0;
		errors              = 0;
		n_items             = 0;
		n_inserted          = 0;
		n_removed           = 0;
		n_empty             = 0;
		n_full              = 0;
		send_idle_pct       = 29;
		recv_idle_pct       = 51;

		// remove from empty, then fill with extremes and tied ranks, overflow, drain a few
		add_row(OP_REMOVE, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, ST_EMPTY, 0);
		add_row(OP_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, ST_INSERTED, 1);
		add_row(OP_INSERT, 32'sh8000_0000, 32'sh8000_0000, 1, ST_INSERTED, 2);
		add_row(OP_INSERT, 1, 0, 1, ST_INSERTED, 3);
		add_row(OP_INSERT, 2, 0, 1, ST_INSERTED, 4);
		add_row(OP_INSERT, -1, -1, 1, ST_INSERTED, 5);
		add_row(OP_INSERT, 3, 0, 1, ST_INSERTED, 6);
		add_row(OP_INSERT, 0, 32'sh7FFF_FFFF, 1, ST_INSERTED, 7);
		add_row(OP_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555, 1, ST_INSERTED, 8);
		add_row(OP_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA, 1, ST_INSERTED, 9);
		add_row(OP_INSERT, 4, 1, 1, ST_INSERTED, 10);
		add_row(OP_INSERT, 5, -2, 1, ST_INSERTED, 11);
		add_row(OP_INSERT, 6, 32'sh8000_0000, 1, ST_INSERTED, 12);
		add_row(OP_INSERT, 7, 32'sh8000_0001, 1, ST_INSERTED, 13);
		add_row(OP_INSERT, 8, 32'sh7FFF_FFFE, 1, ST_INSERTED, 14);
		add_row(OP_INSERT, 9, 0, 1, ST_INSERTED, 15);
		add_row(OP_INSERT, 10, -1, 1, ST_INSERTED, 16);
		add_row(OP_INSERT, 11, 32'sh8000_0000, 1, ST_FULL, 16);
		add_row(OP_REMOVE, 32'sh1234_5678, 32'sh7FFF_FFFF, 0, ST_REMOVED, 0);
		add_row(OP_REMOVE, 32'shFFFF_FFFF, 0, 0, ST_REMOVED, 0);
		add_row(OP_REMOVE, 0, 32'shFFFF_FFFF, 0, ST_REMOVED, 0);
		add_row(OP_REMOVE, 32'sh8000_0000, 32'sh8000_0000, 0, ST_REMOVED, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (table_rows[i])
			send_beat(table_rows[i].op, table_rows[i].value, table_rows[i].rank,
				table_rows[i].fixed, table_rows[i].outcome);
		run_random(RANDOM_ITEMS);

		send_idle_pct = 51;
		recv_idle_pct = 29;
		run_random(RANDOM_ITEMS);

		// no idling; the receiver first holds off so the input side backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_requests++;
		run_random(RANDOM_ITEMS);

		items_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d item beats sent: %0d inserts taken, %0d removes served,", n_items,
			n_inserted, n_removed);
		$display("%0d removes on an empty queue, %0d inserts refused when full", n_empty,
			n_full);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
